// ===== rtl/ppe_pkg.sv =====
// Package for the packed pattern event decoder: types, codes and the phase step function.
`default_nettype none
package ppe_pkg;

    typedef enum logic [2:0] {
        PH_FLAG  = 3'd0,
        PH_NOTE  = 3'd1,
        PH_INSTR = 3'd2,
        PH_VOL   = 3'd3,
        PH_FX    = 3'd4,
        PH_PARAM = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CHAN  = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    localparam logic KIND_EVENT   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // flag byte presence bits
    localparam int HAS_NOTE_BIT  = 7;
    localparam int HAS_INSTR_BIT = 6;
    localparam int HAS_VOL_BIT   = 5;
    localparam int HAS_FX_BIT    = 4;

    localparam logic [15:0] ROW_MAX = 16'hFFFF;

    typedef struct packed {
        logic        result_kind;
        logic [15:0] row_index;
        logic [3:0]  channel;
        logic [3:0]  present_mask;
        logic [7:0]  note;
        logic [7:0]  instrument;
        logic [7:0]  volume;
        logic [7:0]  effect;
        logic [7:0]  effect_param;
        logic [1:0]  status;
        logic        last_result;
    } t_result;

    // First phase after 'from' whose byte the flag announces; PH_FLAG when none.
    function automatic t_phase next_phase(input logic [7:0] flag, input t_phase from);
        logic n;
        logic i;
        logic v;
        logic f;
        t_phase p;
        n = flag[HAS_NOTE_BIT];
        i = flag[HAS_INSTR_BIT];
        v = flag[HAS_VOL_BIT];
        f = flag[HAS_FX_BIT];
        case (from)
            PH_FLAG:  p = n ? PH_NOTE : i ? PH_INSTR : v ? PH_VOL : f ? PH_FX : PH_FLAG;
            PH_NOTE:  p = i ? PH_INSTR : v ? PH_VOL : f ? PH_FX : PH_FLAG;
            PH_INSTR: p = v ? PH_VOL : f ? PH_FX : PH_FLAG;
            PH_VOL:   p = f ? PH_FX : PH_FLAG;
            PH_FX:    p = f ? PH_PARAM : PH_FLAG;
            default:  p = PH_FLAG;
        endcase
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ppe_in_if.sv =====
// Byte input channel of the pattern decoder.
`default_nettype none
interface ppe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/ppe_out_if.sv =====
// Result output channel of the pattern decoder.
`default_nettype none
interface ppe_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [15:0] row_index;
    logic [3:0]  channel;
    logic [3:0]  present_mask;
    logic [7:0]  note;
    logic [7:0]  instrument;
    logic [7:0]  volume;
    logic [7:0]  effect;
    logic [7:0]  effect_param;
    logic [1:0]  status;
    logic        last_result;

    modport source (output valid, output result_kind, output row_index, output channel,
                    output present_mask, output note, output instrument, output volume,
                    output effect, output effect_param, output status, output last_result,
                    input ready);
    modport sink   (input valid, input result_kind, input row_index, input channel,
                    input present_mask, input note, input instrument, input volume,
                    input effect, input effect_param, input status, input last_result,
                    output ready);
    modport monitor (input valid, input ready, input result_kind, input row_index,
                     input channel, input present_mask, input note, input instrument,
                     input volume, input effect, input effect_param, input status,
                     input last_result);
endinterface
`default_nettype wire

// ===== rtl/packed_pattern_event_decoder.sv =====
// Results are registered into a three-entry result queue as a byte transfers.
// Throughput: one byte per cycle while input ready is high; a last byte that
// emits an event yields two results, which drain one per cycle unless stalled.
// Input ready is registered: high while the queue holds at most one result.
// Reset (synchronous, active low) empties the queue, clears the parse state and
// sets r_chans to 16.
`default_nettype none
module packed_pattern_event_decoder #(
    parameter int MAX_CHANNEL_COUNT = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire  [4:0] i_cfg_wr_data,
    ppe_in_if.sink     i_in,
    ppe_out_if.source  o_out
);

    localparam logic [4:0] LIM_MAX = 5'(MAX_CHANNEL_COUNT);

    logic [4:0]           r_chans;
    ppe_pkg::t_phase      r_phase, n_phase;
    logic [7:0]           r_flag, n_flag;
    logic [7:0]           r_note, n_note;
    logic [7:0]           r_instr, n_instr;
    logic [7:0]           r_vol, n_vol;
    logic [7:0]           r_eff, n_eff;
    logic [15:0]          r_row, n_row;
    logic [1:0]           r_err, n_err;
    logic                 r_bad, n_bad;

    ppe_pkg::t_result     r_q [0:2];
    ppe_pkg::t_result     n_q [0:2];
    logic [1:0]           r_cnt, n_cnt;

    logic                 in_fire;
    logic                 pop;
    logic                 done;
    logic                 emit;
    logic [7:0]           param;
    logic [4:0]           lim;
    ppe_pkg::t_result     ev;
    ppe_pkg::t_result     summ;
    ppe_pkg::t_result     first;
    logic [1:0]           push_n;
    logic [1:0]           cnt_s;

    assign in_fire    = i_in.valid && i_in.ready;
    assign pop        = (r_cnt != 2'd0) && o_out.ready;
    assign i_in.ready = (r_cnt <= 2'd1);
    assign lim        = (r_chans > LIM_MAX) ? LIM_MAX : r_chans;

    // byte parsing
    always_comb begin
        n_phase = r_phase;
        n_flag  = r_flag;
        n_note  = r_note;
        n_instr = r_instr;
        n_vol   = r_vol;
        n_eff   = r_eff;
        n_row   = r_row;
        n_err   = r_err;
        n_bad   = r_bad;
        done    = 1'b0;
        param   = 8'd0;
        case (r_phase)
            ppe_pkg::PH_NOTE:  n_note  = i_in.data_byte;
            ppe_pkg::PH_INSTR: n_instr = i_in.data_byte;
            ppe_pkg::PH_VOL:   n_vol   = i_in.data_byte;
            ppe_pkg::PH_FX:    n_eff   = i_in.data_byte;
            ppe_pkg::PH_PARAM: param   = i_in.data_byte;
            default: begin
                if (i_in.data_byte == 8'd0) begin
                    if (r_row != ppe_pkg::ROW_MAX) begin
                        n_row = r_row + 16'd1;
                    end
                end else begin
                    n_flag  = i_in.data_byte;
                    n_note  = 8'd0;
                    n_instr = 8'd0;
                    n_vol   = 8'd0;
                    n_eff   = 8'd0;
                    n_bad   = {1'b0, i_in.data_byte[3:0]} >= lim;
                    if (n_bad && r_err == ppe_pkg::ST_OK) begin
                        n_err = ppe_pkg::ST_BAD_CHAN;
                    end
                end
            end
        endcase
        if (r_phase == ppe_pkg::PH_NOTE || r_phase == ppe_pkg::PH_INSTR ||
            r_phase == ppe_pkg::PH_VOL || r_phase == ppe_pkg::PH_FX ||
            r_phase == ppe_pkg::PH_PARAM) begin
            n_phase = ppe_pkg::next_phase(r_flag, r_phase);
            done    = (n_phase == ppe_pkg::PH_FLAG);
        end else if (i_in.data_byte != 8'd0) begin
            n_phase = ppe_pkg::next_phase(i_in.data_byte, ppe_pkg::PH_FLAG);
            done    = (n_phase == ppe_pkg::PH_FLAG);
        end else begin
            n_phase = ppe_pkg::PH_FLAG;
        end

        emit = done && !n_bad && (n_err == ppe_pkg::ST_OK);

        ev.result_kind  = ppe_pkg::KIND_EVENT;
        ev.row_index    = r_row;
        ev.channel      = n_flag[3:0];
        ev.present_mask = n_flag[7:4];
        ev.note         = n_note;
        ev.instrument   = n_instr;
        ev.volume       = n_vol;
        ev.effect       = n_eff;
        ev.effect_param = param;
        ev.status       = ppe_pkg::ST_OK;
        ev.last_result  = !i_in.last_byte;

        if (i_in.last_byte && n_phase != ppe_pkg::PH_FLAG && n_err == ppe_pkg::ST_OK) begin
            n_err = ppe_pkg::ST_TRUNCATED;
        end
        summ              = '0;
        summ.result_kind  = ppe_pkg::KIND_SUMMARY;
        summ.row_index    = n_row;
        summ.status       = n_err;
        summ.last_result  = 1'b1;

        first  = emit ? ev : summ;
        push_n = in_fire ? (2'(emit) + 2'(i_in.last_byte)) : 2'd0;

        // end of pattern: parse state back to reset values
        if (i_in.last_byte) begin
            n_phase = ppe_pkg::PH_FLAG;
            n_flag  = 8'd0;
            n_note  = 8'd0;
            n_instr = 8'd0;
            n_vol   = 8'd0;
            n_eff   = 8'd0;
            n_row   = 16'd0;
            n_err   = ppe_pkg::ST_OK;
            n_bad   = 1'b0;
        end
    end

    // result queue: pop at the head, then append up to two results
    always_comb begin
        if (pop) begin
            n_q[0] = r_q[1];
            n_q[1] = r_q[2];
            n_q[2] = r_q[2];
        end else begin
            n_q[0] = r_q[0];
            n_q[1] = r_q[1];
            n_q[2] = r_q[2];
        end
        cnt_s = r_cnt - 2'(pop);
        for (int k = 0; k < 3; k++) begin
            if (push_n != 2'd0 && 2'(k) == cnt_s) begin
                n_q[k] = first;
            end
            if (push_n == 2'd2 && 2'(k) == cnt_s + 2'd1) begin
                n_q[k] = summ;
            end
        end
        n_cnt = cnt_s + push_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chans <= 5'd16;
            r_phase <= ppe_pkg::PH_FLAG;
            r_flag  <= 8'd0;
            r_note  <= 8'd0;
            r_instr <= 8'd0;
            r_vol   <= 8'd0;
            r_eff   <= 8'd0;
            r_row   <= 16'd0;
            r_err   <= ppe_pkg::ST_OK;
            r_bad   <= 1'b0;
            r_cnt   <= 2'd0;
        end else begin
            if (i_cfg_wr_en) begin
                r_chans <= i_cfg_wr_data;
            end
            if (in_fire) begin
                r_phase <= n_phase;
                r_flag  <= n_flag;
                r_note  <= n_note;
                r_instr <= n_instr;
                r_vol   <= n_vol;
                r_eff   <= n_eff;
                r_row   <= n_row;
                r_err   <= n_err;
                r_bad   <= n_bad;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
        r_q[2] <= n_q[2];
    end

    assign o_out.valid        = (r_cnt != 2'd0);
    assign o_out.result_kind  = r_q[0].result_kind;
    assign o_out.row_index    = r_q[0].row_index;
    assign o_out.channel      = r_q[0].channel;
    assign o_out.present_mask = r_q[0].present_mask;
    assign o_out.note         = r_q[0].note;
    assign o_out.instrument   = r_q[0].instrument;
    assign o_out.volume       = r_q[0].volume;
    assign o_out.effect       = r_q[0].effect;
    assign o_out.effect_param = r_q[0].effect_param;
    assign o_out.status       = r_q[0].status;
    assign o_out.last_result  = r_q[0].last_result;

endmodule
`default_nettype wire

// ===== rtl/ppe_checker.sv =====
// Port-level checks for the pattern decoder and their binding to the top level.
`default_nettype none
module ppe_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        i_ready,
    input wire        i_result_kind,
    input wire [15:0] i_row_index,
    input wire [3:0]  i_channel,
    input wire [3:0]  i_present_mask,
    input wire [1:0]  i_status,
    input wire        i_last_result
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_row_index) &&
            $stable(i_result_kind) && $stable(i_status))
        else $error("stalled result changed");

    // an event that is not the last result of its byte is followed by the summary
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_ready && i_result_kind == ppe_pkg::KIND_EVENT &&
            !i_last_result |=> i_valid && i_result_kind == ppe_pkg::KIND_SUMMARY)
        else $error("summary missing after event");

    a_ev_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_result_kind == ppe_pkg::KIND_EVENT |-> i_status == ppe_pkg::ST_OK)
        else $error("event carries a status");

    a_summ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_result_kind == ppe_pkg::KIND_SUMMARY |->
            i_last_result && i_channel == 4'd0 && i_present_mask == 4'd0 &&
            i_status != 2'd3)
        else $error("malformed summary");

endmodule

bind packed_pattern_event_decoder ppe_checker u_ppe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_result_kind  (o_out.result_kind),
    .i_row_index    (o_out.row_index),
    .i_channel      (o_out.channel),
    .i_present_mask (o_out.present_mask),
    .i_status       (o_out.status),
    .i_last_result  (o_out.last_result)
);
`default_nettype wire
